>>> sv/oct_pkg.sv
package oct_pkg;

    localparam int DATA_W        = 16;
    localparam int L1_W          = 17;
    localparam int FRAC_BITS_DEF = 15;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

endpackage

>>> sv/oct_ifs.sv
interface oct_in_if;
    logic                               valid;
    logic                               ready;
    logic                               command;
    logic signed [oct_pkg::DATA_W-1:0]  in_x;
    logic signed [oct_pkg::DATA_W-1:0]  in_y;
    logic signed [oct_pkg::DATA_W-1:0]  in_z;

    modport source (output valid, command, in_x, in_y, in_z, input ready);
    modport sink   (input valid, command, in_x, in_y, in_z, output ready);
endinterface

interface oct_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [oct_pkg::DATA_W-1:0]  out_x;
    logic signed [oct_pkg::DATA_W-1:0]  out_y;
    logic signed [oct_pkg::DATA_W-1:0]  out_z;
    logic                               zero_vector;

    modport source (output valid, out_x, out_y, out_z, zero_vector, input ready);
    modport sink   (input valid, out_x, out_y, out_z, zero_vector, output ready);
endinterface

>>> sv/octahedral_normal_codec.sv
// Octahedral normal codec, one transaction per cycle while the sink is ready.
// Stages in order: the front-end and sum-of-squares registers, the one-bit-per-stage square root,
// the one-bit-per-stage dividers, a rounding register and the output register.
// The whole pipeline advances together; a stalled sink holds every stage.
// Reset (synchronous, active low) clears the valid bits of all stages.
module octahedral_normal_codec #(
    parameter int FRAC_BITS = oct_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    oct_in_if.sink       i_in,
    oct_out_if.source    o_out
);

    localparam int DW   = oct_pkg::DATA_W;
    localparam int MW   = (FRAC_BITS + 2 > oct_pkg::L1_W) ? FRAC_BITS + 2 : oct_pkg::L1_W;
    localparam int SQW  = 2 * MW + 4;
    localparam int RB   = SQW / 2;
    localparam int QB   = FRAC_BITS + 2;
    localparam int VW   = (FRAC_BITS + 4 > 18) ? FRAC_BITS + 4 : 18;
    localparam int CW   = 7;
    localparam int C_S0 = 0;
    localparam int C_S1 = 1;
    localparam int C_S2 = 2;
    localparam int C_FOLD = 3;
    localparam int C_ZV = 4;
    localparam int C_CMD = 5;
    localparam int C_FRC = 6;

    localparam logic [MW:0] ONE_S = {{(MW - FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [VW-1:0] ONE_V =
        {{(VW - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [VW-1:0] SAT_HI = VW'(32767);
    localparam logic signed [VW-1:0] SAT_LO = -VW'(32768);

    function automatic logic [MW-1:0] abs_m(input logic [MW:0] v);
        logic [MW:0] t;
        t = v[MW] ? (~v + 1'b1) : v;
        return t[MW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] sat16(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] t;
        t = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
        return t[DW-1:0];
    endfunction

    logic en;

    // front end
    logic [MW:0]    a_x, a_y, a_z, a_w, a_fu, a_fv, a_u, a_v;
    logic [MW-1:0]  a_mx, a_my, a_mz, a_l1;
    logic           a_fold_d;
    logic [CW-1:0]  n_a_ctl;
    logic [MW-1:0]  n_a_n [3];

    logic           r_a_vld;
    logic [CW-1:0]  r_a_ctl;
    logic [MW-1:0]  r_a_n [3];
    logic [MW-1:0]  r_a_l1;

    logic           r_b_vld;
    logic [CW-1:0]  r_b_ctl;
    logic [MW-1:0]  r_b_n [3];
    logic [MW-1:0]  r_b_l1;
    logic [2*MW-1:0] r_b_p [3];

    logic           r_s_vld  [RB+1];
    logic [CW-1:0]  r_s_ctl  [RB+1];
    logic [MW-1:0]  r_s_n    [RB+1][3];
    logic [MW-1:0]  r_s_l1   [RB+1];
    logic [RB:0]    r_s_rem  [RB+1];
    logic [RB-1:0]  r_s_root [RB+1];
    logic [SQW-1:0] r_s_rest [RB+1];

    logic           r_d_vld [QB+1];
    logic [CW-1:0]  r_d_ctl [QB+1];
    logic [RB-1:0]  r_d_d   [QB+1];
    logic [RB:0]    r_d_r   [QB+1][3];
    logic [QB-1:0]  r_d_q   [QB+1][3];

    logic           r_p_vld;
    logic [CW-1:0]  r_p_ctl;
    logic [QB-1:0]  r_p_q [3];

    logic                  r_o_vld;
    logic signed [DW-1:0]  r_o_x, r_o_y, r_o_z;
    logic                  r_o_zv;

    assign en          = !r_o_vld || o_out.ready;
    assign i_in.ready  = en;
    assign o_out.valid = r_o_vld;
    assign o_out.out_x = r_o_x;
    assign o_out.out_y = r_o_y;
    assign o_out.out_z = r_o_z;
    assign o_out.zero_vector = r_o_zv;

    always_comb begin
        a_x  = (MW+1)'(i_in.in_x);
        a_y  = (MW+1)'(i_in.in_y);
        a_z  = (MW+1)'(i_in.in_z);
        a_mx = abs_m(a_x);
        a_my = abs_m(a_y);
        a_mz = abs_m(a_z);
        a_l1 = a_mx + a_my + a_mz;
        a_w  = ONE_S - (MW+1)'(a_mx) - (MW+1)'(a_my);
        a_fold_d = a_w[MW];
        a_fu = ONE_S - (MW+1)'(a_my);
        a_fv = ONE_S - (MW+1)'(a_mx);
        a_u  = a_fold_d ? (a_x[MW] ? (~a_fu + 1'b1) : a_fu) : a_x;
        a_v  = a_fold_d ? (a_y[MW] ? (~a_fv + 1'b1) : a_fv) : a_y;
        n_a_ctl = '0;
        n_a_ctl[C_CMD] = i_in.command;
        if (i_in.command == oct_pkg::CMD_ENCODE) begin
            n_a_ctl[C_S0]   = a_x[MW];
            n_a_ctl[C_S1]   = a_z[MW];
            n_a_ctl[C_FOLD] = a_y[MW];
            n_a_ctl[C_ZV]   = (a_l1 == '0);
            n_a_n[0] = a_mx;
            n_a_n[1] = a_mz;
            n_a_n[2] = '0;
        end else begin
            n_a_ctl[C_S0]   = a_u[MW];
            n_a_ctl[C_S1]   = a_w[MW];
            n_a_ctl[C_S2]   = a_v[MW];
            n_a_ctl[C_FOLD] = a_fold_d;
            n_a_n[0] = abs_m(a_u);
            n_a_n[1] = abs_m(a_w);
            n_a_n[2] = abs_m(a_v);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_s_vld[0] <= 1'b0;
            r_d_vld[0] <= 1'b0;
            r_p_vld  <= 1'b0;
            r_o_vld  <= 1'b0;
        end else if (en) begin
            r_a_vld  <= i_in.valid;
            r_b_vld  <= r_a_vld;
            r_s_vld[0] <= r_b_vld;
            r_d_vld[0] <= r_s_vld[RB];
            r_p_vld  <= r_d_vld[QB];
            r_o_vld  <= r_p_vld;
        end
    end

    // front, squares, sum of squares
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_ctl <= n_a_ctl;
            r_a_l1  <= a_l1;
            r_b_ctl <= r_a_ctl;
            r_b_l1  <= r_a_l1;
            r_s_ctl[0] <= r_b_ctl;
            r_s_l1[0]  <= r_b_l1;
            r_s_rem[0] <= '0;
            r_s_root[0] <= '0;
            r_s_rest[0] <= {(2*MW+2)'(r_b_p[0]) + (2*MW+2)'(r_b_p[1])
                            + (2*MW+2)'(r_b_p[2]), 2'b00};
            for (int i = 0; i < 3; i++) begin
                r_a_n[i] <= n_a_n[i];
                r_b_n[i] <= r_a_n[i];
                r_b_p[i] <= r_a_n[i] * r_a_n[i];
                r_s_n[0][i] <= r_b_n[i];
            end
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < RB; k++) begin : g_sqrt
        logic [RB+2:0] cur;
        logic [RB+1:0] trial;
        logic          ge;
        logic [RB+2:0] diff;

        always_comb begin
            cur   = {r_s_rem[k], r_s_rest[k][SQW-1 -: 2]};
            trial = {r_s_root[k], 2'b01};
            ge    = cur >= (RB+3)'(trial);
            diff  = ge ? (cur - (RB+3)'(trial)) : cur;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_vld[k+1] <= 1'b0;
            end else if (en) begin
                r_s_vld[k+1] <= r_s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s_ctl[k+1]  <= r_s_ctl[k];
                r_s_l1[k+1]   <= r_s_l1[k];
                r_s_n[k+1]    <= r_s_n[k];
                r_s_rem[k+1]  <= diff[RB:0];
                r_s_root[k+1] <= {r_s_root[k][RB-2:0], ge};
                r_s_rest[k+1] <= {r_s_rest[k][SQW-3:0], 2'b00};
            end
        end
    end

    // divisor select
    logic [RB:0]    d0_sum;
    logic [RB-1:0]  d0_len;
    logic [RB-1:0]  d0_d;
    logic [CW-1:0]  d0_ctl;

    always_comb begin
        d0_sum = {1'b0, r_s_root[RB]} + 1'b1;
        d0_len = d0_sum[RB:1];
        d0_ctl = r_s_ctl[RB];
        if (r_s_ctl[RB][C_CMD] == oct_pkg::CMD_DECODE) begin
            d0_d = d0_len;
            d0_ctl[C_FRC] = (d0_len == '0);
        end else begin
            d0_d = RB'(r_s_l1[RB]);
            d0_ctl[C_FRC] = r_s_ctl[RB][C_ZV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_ctl[0] <= d0_ctl;
            r_d_d[0]   <= d0_d;
            for (int i = 0; i < 3; i++) begin
                r_d_r[0][i] <= (RB+1)'(r_s_n[RB][i]);
                r_d_q[0][i] <= '0;
            end
        end
    end

    // restoring dividers, one quotient bit per stage in each lane
    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [RB+1:0] d2;
        logic [RB+1:0] r2   [3];
        logic          ge   [3];
        logic [RB+1:0] rn   [3];

        always_comb begin
            d2 = {1'b0, r_d_d[k], 1'b0};
            for (int i = 0; i < 3; i++) begin
                r2[i] = {r_d_r[k][i], 1'b0};
                ge[i] = r2[i] >= d2;
                rn[i] = ge[i] ? (r2[i] - d2) : r2[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[k+1] <= 1'b0;
            end else if (en) begin
                r_d_vld[k+1] <= r_d_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d_ctl[k+1] <= r_d_ctl[k];
                r_d_d[k+1]   <= r_d_d[k];
                for (int i = 0; i < 3; i++) begin
                    r_d_r[k+1][i] <= rn[i][RB:0];
                    r_d_q[k+1][i] <= {r_d_q[k][i][QB-2:0], ge[i]};
                end
            end
        end
    end

    // round, then fold, sign and saturate
    logic [QB:0] p1_sum [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p1_sum[i] = {1'b0, r_d_q[QB][i]} + 1'b1;
        end
    end

    logic signed [VW-1:0] p2_q [3];
    logic signed [VW-1:0] p2_m [3];
    logic signed [VW-1:0] p2_v [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p2_q[i] = VW'(r_p_q[i]);
        end
        if (r_p_ctl[C_CMD] == oct_pkg::CMD_ENCODE && r_p_ctl[C_FOLD]) begin
            p2_m[0] = ONE_V - p2_q[1];
            p2_m[1] = ONE_V - p2_q[0];
        end else begin
            p2_m[0] = p2_q[0];
            p2_m[1] = p2_q[1];
        end
        p2_m[2] = (r_p_ctl[C_CMD] == oct_pkg::CMD_ENCODE) ? '0 : p2_q[2];
        p2_v[0] = r_p_ctl[C_S0] ? -p2_m[0] : p2_m[0];
        p2_v[1] = r_p_ctl[C_S1] ? -p2_m[1] : p2_m[1];
        p2_v[2] = r_p_ctl[C_S2] ? -p2_m[2] : p2_m[2];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_ctl <= r_d_ctl[QB];
            for (int i = 0; i < 3; i++) begin
                r_p_q[i] <= p1_sum[i][QB:1];
            end
            if (r_p_ctl[C_FRC]) begin
                r_o_x <= '0;
                r_o_y <= '0;
                r_o_z <= '0;
            end else begin
                r_o_x <= sat16(p2_v[0]);
                r_o_y <= sat16(p2_v[1]);
                r_o_z <= sat16(p2_v[2]);
            end
            r_o_zv <= r_p_ctl[C_ZV];
        end
    end

`ifndef SYNTHESIS
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && r_o_zv |-> r_o_x == '0 && r_o_y == '0 && r_o_z == '0)
        else $error("zero vector result carries nonzero components");

    a_dec_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_vld[0] && r_d_ctl[0][C_CMD] == oct_pkg::CMD_DECODE |-> !r_d_ctl[0][C_FRC])
        else $error("decode length rounded to zero");

    a_enc_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_vld[0] && r_d_ctl[0][C_CMD] == oct_pkg::CMD_ENCODE && !r_d_ctl[0][C_ZV]
        |-> r_d_d[0] != '0)
        else $error("encode divisor zero without zero vector flag");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_vld[QB] && !r_d_ctl[QB][C_FRC]
        |-> (RB+2)'(r_d_r[QB][0]) < {1'b0, r_d_d[QB], 1'b0})
        else $error("divider remainder out of range");
`endif

endmodule

>>> tb/sv/octahedral_normal_codec_test.sv
`timescale 1ns / 100ps

module octahedral_normal_codec_test;

    localparam int FB      = oct_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = 42;

    typedef struct packed {
        logic                              command;
        logic signed [oct_pkg::DATA_W-1:0] x;
        logic signed [oct_pkg::DATA_W-1:0] y;
        logic signed [oct_pkg::DATA_W-1:0] z;
    } t_vec_in;

    typedef struct packed {
        logic signed [oct_pkg::DATA_W-1:0] x;
        logic signed [oct_pkg::DATA_W-1:0] y;
        logic signed [oct_pkg::DATA_W-1:0] z;
        logic                              zero_vector;
    } t_vec_out;

    typedef struct {
        t_vec_in  stim;
        bit       typed;
        t_vec_out want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    oct_in_if  in_ch ();
    oct_out_if out_ch ();

    octahedral_normal_codec u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #1 i_clk = ~i_clk;

    t_vec_out codec_results_due[$];
    int       mismatches = 0;
    bit       no_idle    = 1'b0;
    bit       hold_off   = 1'b0;
    bit       stim_done  = 1'b0;

    initial begin
        in_ch.valid   = 1'b0;
        in_ch.command = oct_pkg::CMD_ENCODE;
        in_ch.in_x    = '0;
        in_ch.in_y    = '0;
        in_ch.in_z    = '0;
        out_ch.ready  = 1'b0;
    end

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic signed [oct_pkg::DATA_W-1:0] clamp16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[oct_pkg::DATA_W-1:0];
    endfunction

    function automatic longint quot_nearest(longint n, longint unsigned d);
        longint unsigned a;
        longint unsigned q;
        a = longint'(mag(n)) << FB;
        q = (2 * a + d) / (2 * d);
        return n < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned root_bits(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        for (int i = 0; i < 32; i++) begin
            b = 64'd1 << (62 - 2 * i);
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic t_vec_out octahedral_map(t_vec_in s);
        t_vec_out      r;
        longint        one;
        longint        a;
        longint        b;
        longint        c;
        longint        u;
        longint        v;
        longint        w;
        longint        nu;
        longint        nv;
        longint unsigned l1;
        longint unsigned len2;
        longint unsigned len;
        one = longint'(1) << FB;
        a = s.x;
        b = s.y;
        c = s.z;
        r = '0;
        if (s.command == oct_pkg::CMD_ENCODE) begin
            l1 = mag(a) + mag(b) + mag(c);
            if (l1 == 0) begin
                r.zero_vector = 1'b1;
                return r;
            end
            u = quot_nearest(a, l1);
            v = quot_nearest(c, l1);
            if (b < 0) begin
                nu = (one - mag(v)) * (a >= 0 ? 1 : -1);
                nv = (one - mag(u)) * (c >= 0 ? 1 : -1);
                u = nu;
                v = nv;
            end
            r.x = clamp16(u);
            r.y = clamp16(v);
            return r;
        end
        u = a;
        v = b;
        w = one - mag(a) - mag(b);
        if (w < 0) begin
            u = (one - mag(b)) * (a >= 0 ? 1 : -1);
            v = (one - mag(a)) * (b >= 0 ? 1 : -1);
        end
        len2 = u * u + v * v + w * w;
        len = (root_bits(len2 << 2) + 1) >> 1;
        if (len != 0) begin
            r.x = clamp16(quot_nearest(u, len));
            r.y = clamp16(quot_nearest(w, len));
            r.z = clamp16(quot_nearest(v, len));
        end
        return r;
    endfunction

    task automatic report(string what, t_vec_out got, t_vec_out want);
        mismatches++;
        $display("mismatch %s: got %0d %0d %0d %0b want %0d %0d %0d %0b", what,
            got.x, got.y, got.z, got.zero_vector, want.x, want.y, want.z,
            want.zero_vector);
    endtask

    function automatic t_dir_row row(logic cmd, int x, int y, int z);
        t_dir_row d;
        d.stim  = '{cmd, 16'(x), 16'(y), 16'(z)};
        d.typed = 1'b0;
        d.want  = '0;
        return d;
    endfunction

    function automatic t_dir_row row_typed(logic cmd, int x, int y, int z,
                                           int ox, int oy, int oz, bit zv);
        t_dir_row d;
        d       = row(cmd, x, y, z);
        d.typed = 1'b1;
        d.want  = '{16'(ox), 16'(oy), 16'(oz), zv};
        return d;
    endfunction

    t_dir_row directed[$];

    task automatic offer(t_vec_in s, bit typed, t_vec_out want);
        if (!no_idle && $urandom_range(99) < 29) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
            while (!no_idle && $urandom_range(99) < 29) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= s.command;
        in_ch.in_x    <= s.x;
        in_ch.in_y    <= s.y;
        in_ch.in_z    <= s.z;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        codec_results_due.push_back(typed ? want : octahedral_map(s));
    endtask

    function automatic logic signed [oct_pkg::DATA_W-1:0] rand_field();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(8)) - 16'sd4;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        t_vec_in s;
        directed.push_back(row_typed(oct_pkg::CMD_ENCODE, 0, 0, 0, 0, 0, 0, 1));
        directed.push_back(row_typed(oct_pkg::CMD_ENCODE, 0, 100, 0, 0, 0, 0, 0));
        directed.push_back(row_typed(oct_pkg::CMD_ENCODE, 1, 0, 0, 32767, 0, 0, 0));
        directed.push_back(row_typed(oct_pkg::CMD_ENCODE, 0, 0, -5, 0, -32768, 0, 0));
        directed.push_back(row_typed(oct_pkg::CMD_ENCODE, 0, -7, 0, 32767, 32767, 0, 0));
        directed.push_back(row_typed(oct_pkg::CMD_DECODE, 0, 0, 0, 0, 32767, 0, 0));
        directed.push_back(row(oct_pkg::CMD_ENCODE, 32767, 32767, 32767));
        directed.push_back(row(oct_pkg::CMD_ENCODE, -32768, -32768, -32768));
        directed.push_back(row(oct_pkg::CMD_ENCODE, -32768, 0, 0));
        directed.push_back(row(oct_pkg::CMD_ENCODE, 1, -1, -1));
        directed.push_back(row(oct_pkg::CMD_ENCODE, -3, -1, 0));
        directed.push_back(row(oct_pkg::CMD_ENCODE, 0, -1, 0));
        directed.push_back(row(oct_pkg::CMD_ENCODE, 1, 1, 1));
        directed.push_back(row(oct_pkg::CMD_DECODE, 32767, 32767, 0));
        directed.push_back(row(oct_pkg::CMD_DECODE, -32768, -32768, -1));
        directed.push_back(row(oct_pkg::CMD_DECODE, 16384, 16384, 0));
        directed.push_back(row(oct_pkg::CMD_DECODE, 16384, 16385, 0));
        directed.push_back(row(oct_pkg::CMD_DECODE, -32768, 0, 0));
        directed.push_back(row(oct_pkg::CMD_DECODE, 0, -32768, 32767));
        directed.push_back(row(oct_pkg::CMD_DECODE, 0, 32767, 0));
        directed.push_back(row(oct_pkg::CMD_DECODE, -1, 1, 0));
        directed.push_back(row(oct_pkg::CMD_DECODE, 12345, -20000, 0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i]) offer(directed[i].stim, directed[i].typed, directed[i].want);
        for (int n = 0; n < 550; n++) begin
            no_idle  = (n >= 150 && n < 250);
            hold_off = (n >= 300 && n < 400);
            s.command = 1'($urandom_range(1));
            s.x = rand_field();
            s.y = rand_field();
            s.z = rand_field();
            offer(s, 1'b0, '0);
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        bit stretch_done;
        stretch_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off && !stretch_done) begin
                stretch_done = 1'b1;
                out_ch.ready <= 1'b0;
                for (int k = 0; k < 120; k++) @(posedge i_clk);
            end
            out_ch.ready <= no_idle || $urandom_range(99) >= 29;
        end
    end

    always @(posedge i_clk) begin
        t_vec_out got;
        t_vec_out want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.zero_vector};
            if (codec_results_due.size() == 0) begin
                report("unexpected transaction", got, '0);
            end else begin
                want = codec_results_due.pop_front();
                if (got.x !== want.x) report("out_x", got, want);
                if (got.y !== want.y) report("out_y", got, want);
                if (got.z !== want.z) report("out_z", got, want);
                if (got.zero_vector !== want.zero_vector) report("zero_vector", got, want);
            end
        end
    end

    initial begin
        wait (stim_done);
        while (codec_results_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
